FILE: design/hrt_pkg.sv
`timescale 1ns / 1ps

package hrt_pkg;

    // Field length limit and number of header or query entries.
    localparam int MAX_FIELD   = 4096;
    localparam int MAX_ENTRIES = 32;

    localparam int FIELD_LEN_W = 13;
    localparam int ENTRY_W     = 5;

    localparam logic [FIELD_LEN_W-1:0] FIELD_LEN_MAX = FIELD_LEN_W'(MAX_FIELD);
    localparam logic [ENTRY_W-1:0]     ENTRY_LAST    = ENTRY_W'(MAX_ENTRIES - 1);

    // Bytes of interest in the request stream.
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_SP    = 8'd32;
    localparam logic [7:0] BYTE_COLON = 8'h3a;
    localparam logic [7:0] BYTE_AMP   = 8'h26;
    localparam logic [7:0] BYTE_EQ    = 8'h3d;

    // Field classes carried on the result stream.
    localparam logic [2:0] CLS_METHOD   = 3'd0;
    localparam logic [2:0] CLS_PATH     = 3'd1;
    localparam logic [2:0] CLS_PROTOCOL = 3'd2;
    localparam logic [2:0] CLS_HNAME    = 3'd3;
    localparam logic [2:0] CLS_HVALUE   = 3'd4;
    localparam logic [2:0] CLS_QKEY     = 3'd5;
    localparam logic [2:0] CLS_QVALUE   = 3'd6;
    localparam logic [2:0] CLS_HDR_END  = 3'd7;

    // Recognized header ids.
    localparam logic [1:0] HDR_OTHER        = 2'd0;
    localparam logic [1:0] HDR_CONTENT_TYPE = 2'd1;
    localparam logic [1:0] HDR_ACCEPT       = 2'd2;

    localparam logic [3:0] CT_NAME_LEN  = 4'd12;
    localparam logic [3:0] ACC_NAME_LEN = 4'd6;
    localparam logic [3:0] NAME_POS_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_PATH   = 3'd1,
        PH_PROTO  = 3'd2,
        PH_HNAME  = 3'd3,
        PH_HVAL   = 3'd4,
        PH_QKEY   = 3'd5,
        PH_QVAL   = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic               overflow;
        logic [ENTRY_W-1:0] entry_index;
        logic [1:0]         header_id;
        logic               field_end;
        logic [7:0]         out_byte;
        logic [2:0]         field_class;
    } result_t;

    function automatic logic [7:0] ct_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "T";
            4'd9:    c = "y";
            4'd10:   c = "p";
            4'd11:   c = "e";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] acc_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "A";
            4'd1:    c = "c";
            4'd2:    c = "c";
            4'd3:    c = "e";
            4'd4:    c = "p";
            4'd5:    c = "t";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: design/hrt_in_stage.sv
`timescale 1ns / 1ps

module hrt_in_stage
    import hrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       advance,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Take a new byte when empty or when the held byte moves on this cycle.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

FILE: design/hrt_core.sv
`timescale 1ns / 1ps

module hrt_core
    import hrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] item_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t                 phase_reg, phase_next;
    logic                   trim_reg, trim_next;
    logic [3:0]             name_pos_reg, name_pos_next;
    logic                   ct_match_reg, ct_match_next;
    logic                   acc_match_reg, acc_match_next;
    logic [1:0]             cur_hdr_reg, cur_hdr_next;
    logic [FIELD_LEN_W-1:0] field_len_reg, field_len_next;
    logic [ENTRY_W-1:0]     entry_reg, entry_next;

    logic                   len_full;
    logic [FIELD_LEN_W-1:0] len_bumped;
    logic                   entry_full;
    logic [ENTRY_W-1:0]     entry_bumped;
    logic [1:0]             name_id;

    always_comb
    begin
        len_full     = (field_len_reg >= FIELD_LEN_MAX);
        len_bumped   = len_full ? FIELD_LEN_MAX : field_len_reg + 1'b1;
        entry_full   = (entry_reg >= ENTRY_LAST);
        entry_bumped = entry_full ? ENTRY_LAST : entry_reg + 1'b1;

        if (ct_match_reg && name_pos_reg == CT_NAME_LEN)
            name_id = HDR_CONTENT_TYPE;
        else if (acc_match_reg && name_pos_reg == ACC_NAME_LEN)
            name_id = HDR_ACCEPT;
        else
            name_id = HDR_OTHER;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        trim_next      = trim_reg;
        name_pos_next  = name_pos_reg;
        ct_match_next  = ct_match_reg;
        acc_match_next = acc_match_reg;
        cur_hdr_next   = cur_hdr_reg;
        field_len_next = field_len_reg;
        entry_next     = entry_reg;

        res_valid       = 1'b0;
        res.field_class = CLS_METHOD;
        res.out_byte    = 8'd0;
        res.field_end   = 1'b0;
        res.header_id   = HDR_OTHER;
        res.entry_index = entry_reg;
        res.overflow    = 1'b0;

        if (phase_reg != PH_DONE && item_byte != BYTE_CR)
        begin
            case (phase_reg)
                PH_METHOD, PH_PATH:
                begin
                    res_valid       = 1'b1;
                    res.field_class = (phase_reg == PH_METHOD) ? CLS_METHOD : CLS_PATH;
                    if (item_byte == BYTE_SP)
                    begin
                        res.field_end  = 1'b1;
                        phase_next     = (phase_reg == PH_METHOD) ? PH_PATH : PH_PROTO;
                        field_len_next = '0;
                    end
                    else
                    begin
                        res.out_byte   = item_byte;
                        res.overflow   = len_full;
                        field_len_next = len_bumped;
                    end
                end
                PH_PROTO:
                begin
                    res_valid       = 1'b1;
                    res.field_class = CLS_PROTOCOL;
                    if (item_byte == BYTE_LF)
                    begin
                        res.field_end  = 1'b1;
                        phase_next     = PH_HNAME;
                        trim_next      = 1'b1;
                        name_pos_next  = '0;
                        ct_match_next  = 1'b1;
                        acc_match_next = 1'b1;
                        field_len_next = '0;
                    end
                    else
                    begin
                        res.out_byte   = item_byte;
                        res.overflow   = len_full;
                        field_len_next = len_bumped;
                    end
                end
                PH_HNAME:
                begin
                    if (item_byte == BYTE_LF)
                    begin
                        // Blank line (or a name with no colon): headers are over, query pairs follow.
                        res_valid       = 1'b1;
                        res.field_class = CLS_HDR_END;
                        res.field_end   = 1'b1;
                        phase_next      = PH_QKEY;
                        entry_next      = '0;
                        name_pos_next   = '0;
                        ct_match_next   = 1'b1;
                        acc_match_next  = 1'b1;
                        field_len_next  = '0;
                    end
                    else if (item_byte == BYTE_COLON)
                    begin
                        res_valid       = 1'b1;
                        res.field_class = CLS_HNAME;
                        res.field_end   = 1'b1;
                        res.header_id   = name_id;
                        cur_hdr_next    = name_id;
                        phase_next      = PH_HVAL;
                        trim_next       = 1'b1;
                        name_pos_next   = '0;
                        ct_match_next   = 1'b1;
                        acc_match_next  = 1'b1;
                        field_len_next  = '0;
                    end
                    else if (item_byte != BYTE_SP)
                    begin
                        ct_match_next  = (name_pos_reg < CT_NAME_LEN)
                                       ? (ct_match_reg && item_byte == ct_char(name_pos_reg))
                                       : 1'b0;
                        acc_match_next = (name_pos_reg < ACC_NAME_LEN)
                                       ? (acc_match_reg && item_byte == acc_char(name_pos_reg))
                                       : 1'b0;
                        if (name_pos_reg < NAME_POS_MAX)
                            name_pos_next = name_pos_reg + 1'b1;
                        res_valid       = 1'b1;
                        res.field_class = CLS_HNAME;
                        res.out_byte    = item_byte;
                        res.overflow    = len_full;
                        field_len_next  = len_bumped;
                    end
                end
                PH_HVAL:
                begin
                    if (item_byte == BYTE_LF)
                    begin
                        res_valid       = 1'b1;
                        res.field_class = CLS_HVALUE;
                        res.field_end   = 1'b1;
                        res.header_id   = cur_hdr_reg;
                        res.overflow    = entry_full;
                        entry_next      = entry_bumped;
                        cur_hdr_next    = HDR_OTHER;
                        trim_next       = 1'b1;
                        phase_next      = PH_HNAME;
                        name_pos_next   = '0;
                        ct_match_next   = 1'b1;
                        acc_match_next  = 1'b1;
                        field_len_next  = '0;
                    end
                    else if (!(trim_reg && item_byte == BYTE_SP))
                    begin
                        trim_next       = 1'b0;
                        res_valid       = 1'b1;
                        res.field_class = CLS_HVALUE;
                        res.out_byte    = item_byte;
                        res.header_id   = cur_hdr_reg;
                        res.overflow    = len_full;
                        field_len_next  = len_bumped;
                    end
                end
                PH_QKEY:
                begin
                    res_valid       = 1'b1;
                    res.field_class = CLS_QKEY;
                    if (item_byte == BYTE_EQ)
                    begin
                        res.field_end  = 1'b1;
                        phase_next     = PH_QVAL;
                        field_len_next = '0;
                    end
                    else if (item_byte == BYTE_LF)
                    begin
                        res.field_end  = 1'b1;
                        res.overflow   = entry_full;
                        entry_next     = entry_bumped;
                        phase_next     = PH_DONE;
                        field_len_next = '0;
                    end
                    else
                    begin
                        res.out_byte   = item_byte;
                        res.overflow   = len_full;
                        field_len_next = len_bumped;
                    end
                end
                PH_QVAL:
                begin
                    res_valid       = 1'b1;
                    res.field_class = CLS_QVALUE;
                    if (item_byte == BYTE_AMP || item_byte == BYTE_LF)
                    begin
                        res.field_end  = 1'b1;
                        res.overflow   = entry_full;
                        entry_next     = entry_bumped;
                        phase_next     = (item_byte == BYTE_LF) ? PH_DONE : PH_QKEY;
                        field_len_next = '0;
                    end
                    else
                    begin
                        res.out_byte   = item_byte;
                        res.overflow   = len_full;
                        field_len_next = len_bumped;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            trim_reg      <= 1'b1;
            name_pos_reg  <= '0;
            ct_match_reg  <= 1'b1;
            acc_match_reg <= 1'b1;
            cur_hdr_reg   <= HDR_OTHER;
            field_len_reg <= '0;
            entry_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            trim_reg      <= trim_next;
            name_pos_reg  <= name_pos_next;
            ct_match_reg  <= ct_match_next;
            acc_match_reg <= acc_match_next;
            cur_hdr_reg   <= cur_hdr_next;
            field_len_reg <= field_len_next;
            entry_reg     <= entry_next;
        end
    end

endmodule

FILE: design/hrt_out_stage.sv
`timescale 1ns / 1ps

module hrt_out_stage
    import hrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        res_valid,
    input  result_t     res,
    output logic        space,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic [2:0]  m_tuser
);

    logic    valid_reg;
    result_t data_reg;

    assign space    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.overflow, data_reg.entry_index,
                       data_reg.header_id, data_reg.out_byte};
    assign m_tlast  = data_reg.field_end;
    assign m_tuser  = data_reg.field_class;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

FILE: design/http_request_tokenizer.sv
`timescale 1ns / 1ps
// HTTP request tokenizer: one raw request byte per transaction in, at most
// one tagged token per transaction out.
// Input channel s_*: tdata[7:0] carries the request byte.
// Output channel m_*: tuser is the field class (method, path, protocol,
// header name, header value, query key, query value, headers end), tlast
// marks the end of that field, tdata carries the kept byte (zero on an end
// marker), the recognized header id (Content-Type or Accept), the current
// header/query entry index and the overflow flag.
// CR bytes, spaces in header names, leading spaces of header values and
// everything after the final query LF produce no output transaction.
// An accepted byte is held in the input register and parsed there; its
// token is loaded into the output register once that register is free.
// Throughput: one byte per cycle while m_tready stays high; the per-byte
// work is a single phase update plus two name compares between the input
// and output registers. When the receiver stalls, the token holds in the
// output register and the input register still takes one more byte; after
// that s_tready drops until m_tready returns.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the method phase with all counters cleared.

module http_request_tokenizer
    import hrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] header_id,
                                   // [14:10] entry_index, [15] overflow
    output logic        m_tlast,   // field_end
    output logic [2:0]  m_tuser    // [2:0] field_class
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       out_space;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // Advance the held byte through the parser whenever the output stage
    // can take its token.
    assign advance = item_valid && out_space;

    hrt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    hrt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (item_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    hrt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .space     (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hrt_pkg::*;

    // Shape of the request that follows the directed rows.
    localparam int HDR_COUNT      = 36;    // enough to run the entry index into saturation
    localparam int QUERY_PAIRS    = 36;
    localparam int LONG_VALUE_LEN = 100;   // one header value far longer than the rest
    localparam int DONE_TAIL      = 20;    // bytes after the final LF, all ignored
    localparam int DRAIN_CYCLES   = 8;

    // Header names the tokenizer recognizes, first character in the top byte.
    localparam logic [8*12-1:0] CT_TEXT  = "Content-Type";
    localparam logic [8*6-1:0]  ACC_TEXT = "Accept";

    // How a stimulus row is checked: by the tokenizer model, against a token
    // typed into the table, or as a byte that must give no token at all.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_GIVEN,
        ROW_DROPPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;
        result_t    tok;
    } row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    // Percent of cycles in which each side idles; the main sequence moves
    // these through three phases.
    int tx_idle_pct = 27;
    int rx_idle_pct = 72;

    int mismatches     = 0;
    int tokens_checked = 0;
    int bytes_sent     = 0;

    result_t    pending_tokens[$];   // tokens owed by the block, oldest first
    row_t       directed_rows[$];
    logic [7:0] body_bytes[$];       // the rest of the request, built at time zero

    // Tokenizer model state, at its reset values (reset happens once).
    phase_t                 tk_phase    = PH_METHOD;
    logic                   tk_trim     = 1'b1;
    logic [3:0]             tk_name_pos = 4'd0;
    logic                   tk_ct_ok    = 1'b1;
    logic                   tk_acc_ok   = 1'b1;
    logic [1:0]             tk_hdr      = HDR_OTHER;
    logic [FIELD_LEN_W-1:0] tk_len      = '0;
    logic [ENTRY_W-1:0]     tk_entry    = '0;

    http_request_tokenizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Tokenizer model
    // ------------------------------------------------------------------

    // Open a new name or value: clear the match trackers and the length.
    function automatic void restart_field_name();
        tk_name_pos = 4'd0;
        tk_ct_ok    = 1'b1;
        tk_acc_ok   = 1'b1;
        tk_len      = '0;
    endfunction

    // Count one kept data byte; flag it once the field is at its limit.
    function automatic logic count_data();
        if (tk_len >= FIELD_LEN_MAX)
        begin
            tk_len = FIELD_LEN_MAX;
            return 1'b1;
        end
        tk_len++;
        return 1'b0;
    endfunction

    // Advance to the next header or query entry; hold at the last index.
    function automatic logic bump_entry();
        if (tk_entry >= ENTRY_LAST)
        begin
            tk_entry = ENTRY_LAST;
            return 1'b1;
        end
        tk_entry++;
        return 1'b0;
    endfunction

    // Work out the token (if any) that one request byte produces, and
    // advance the model state.
    function automatic void tokenize_byte(input logic [7:0] b, output logic emits,
                                          output result_t tok);
        emits           = 1'b0;
        tok             = '0;
        tok.entry_index = tk_entry;   // index as it stood before this byte
        if (tk_phase == PH_DONE || b == BYTE_CR)
            return;
        emits = 1'b1;
        case (tk_phase)
            PH_METHOD, PH_PATH:
            begin
                tok.field_class = (tk_phase == PH_METHOD) ? CLS_METHOD : CLS_PATH;
                if (b == BYTE_SP)
                begin
                    tok.field_end = 1'b1;
                    tk_phase      = (tk_phase == PH_METHOD) ? PH_PATH : PH_PROTO;
                    tk_len        = '0;
                end
                else
                begin
                    tok.out_byte = b;
                    tok.overflow = count_data();
                end
            end
            PH_PROTO:
            begin
                tok.field_class = CLS_PROTOCOL;
                if (b == BYTE_LF)
                begin
                    tok.field_end = 1'b1;
                    tk_phase      = PH_HNAME;
                    tk_trim       = 1'b1;
                    restart_field_name();
                end
                else
                begin
                    tok.out_byte = b;
                    tok.overflow = count_data();
                end
            end
            PH_HNAME:
            begin
                tok.field_class = CLS_HNAME;
                if (b == BYTE_SP)
                    emits = 1'b0;
                else if (b == BYTE_LF)
                begin
                    // blank line (or a name with no colon): headers are over
                    tok.field_class = CLS_HDR_END;
                    tok.field_end   = 1'b1;
                    tk_phase        = PH_QKEY;
                    tk_entry        = '0;
                    restart_field_name();
                end
                else if (b == BYTE_COLON)
                begin
                    if (tk_ct_ok && tk_name_pos == CT_NAME_LEN)
                        tok.header_id = HDR_CONTENT_TYPE;
                    else if (tk_acc_ok && tk_name_pos == ACC_NAME_LEN)
                        tok.header_id = HDR_ACCEPT;
                    else
                        tok.header_id = HDR_OTHER;
                    tok.field_end = 1'b1;
                    tk_hdr        = tok.header_id;
                    tk_phase      = PH_HVAL;
                    tk_trim       = 1'b1;
                    restart_field_name();
                end
                else
                begin
                    // exact match: every position must agree and the length must fit
                    if (tk_name_pos < CT_NAME_LEN)
                        tk_ct_ok = tk_ct_ok && (b == CT_TEXT[8*(11 - tk_name_pos) +: 8]);
                    else
                        tk_ct_ok = 1'b0;
                    if (tk_name_pos < ACC_NAME_LEN)
                        tk_acc_ok = tk_acc_ok && (b == ACC_TEXT[8*(5 - tk_name_pos) +: 8]);
                    else
                        tk_acc_ok = 1'b0;
                    if (tk_name_pos < NAME_POS_MAX)
                        tk_name_pos++;
                    tok.out_byte = b;
                    tok.overflow = count_data();
                end
            end
            PH_HVAL:
            begin
                tok.field_class = CLS_HVALUE;
                tok.header_id   = tk_hdr;
                if (tk_trim && b == BYTE_SP)
                    emits = 1'b0;
                else if (b == BYTE_LF)
                begin
                    tok.field_end = 1'b1;
                    tok.overflow  = bump_entry();
                    tk_hdr        = HDR_OTHER;
                    tk_trim       = 1'b1;
                    tk_phase      = PH_HNAME;
                    restart_field_name();
                end
                else
                begin
                    tk_trim      = 1'b0;
                    tok.out_byte = b;
                    tok.overflow = count_data();
                end
            end
            PH_QKEY:
            begin
                tok.field_class = CLS_QKEY;
                if (b == BYTE_EQ)
                begin
                    tok.field_end = 1'b1;
                    tk_phase      = PH_QVAL;
                    tk_len        = '0;
                end
                else if (b == BYTE_LF)
                begin
                    tok.field_end = 1'b1;
                    tok.overflow  = bump_entry();
                    tk_phase      = PH_DONE;
                    tk_len        = '0;
                end
                else
                begin
                    tok.out_byte = b;
                    tok.overflow = count_data();
                end
            end
            default:
            begin
                tok.field_class = CLS_QVALUE;
                if (b == BYTE_AMP || b == BYTE_LF)
                begin
                    tok.field_end = 1'b1;
                    tok.overflow  = bump_entry();
                    tk_phase      = (b == BYTE_LF) ? PH_DONE : PH_QKEY;
                    tk_len        = '0;
                end
                else
                begin
                    tok.out_byte = b;
                    tok.overflow = count_data();
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic result_t make_token(input logic [2:0] cls, input logic [7:0] ob,
                                           input logic fend, input logic [1:0] hid,
                                           input logic [4:0] idx, input logic ovf);
        result_t t;
        t.field_class = cls;
        t.out_byte    = ob;
        t.field_end   = fend;
        t.header_id   = hid;
        t.entry_index = idx;
        t.overflow    = ovf;
        return t;
    endfunction

    task automatic add_row(input row_kind_t k, input logic [7:0] d, input result_t t);
        row_t r;
        r.kind = k;
        r.data = d;
        r.tok  = t;
        directed_rows.push_back(r);
    endtask

    // Random byte that is neither of two delimiters.
    function automatic logic [7:0] rand_data(input logic [7:0] stop_a, input logic [7:0] stop_b);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == stop_a || b == stop_b);
        return b;
    endfunction

    task automatic push_text(input string s);
        for (int j = 0; j < s.len(); j++)
            body_bytes.push_back(s[j]);
    endtask

    // Drive one request byte, wait for its transaction, then book the token
    // it owes.
    task automatic feed(input row_t r);
        logic    emits;
        result_t tok;
        // idle the sender for a random number of cycles
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tokenize_byte(r.data, emits, tok);
        if (r.kind == ROW_GIVEN)
            pending_tokens.push_back(r.tok);
        else if (r.kind == ROW_PREDICT && emits)
            pending_tokens.push_back(tok);
        bytes_sent++;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH token %0d %s: got %0d, expected %0d",
                 tokens_checked, what, got, want);
    endtask

    task automatic check_token(input result_t want);
        if (m_tuser !== want.field_class)
            flag_mismatch("field_class", m_tuser, want.field_class);
        if (m_tdata[7:0] !== want.out_byte)
            flag_mismatch("out_byte", m_tdata[7:0], want.out_byte);
        if (m_tlast !== want.field_end)
            flag_mismatch("field_end", m_tlast, want.field_end);
        if (m_tdata[9:8] !== want.header_id)
            flag_mismatch("header_id", m_tdata[9:8], want.header_id);
        if (m_tdata[14:10] !== want.entry_index)
            flag_mismatch("entry_index", m_tdata[14:10], want.entry_index);
        if (m_tdata[15] !== want.overflow)
            flag_mismatch("overflow", m_tdata[15], want.overflow);
        tokens_checked++;
    endtask

    // Receiver: check every output transaction against the oldest owed
    // token, then pick the next cycle's ready at random.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tokens.size() == 0)
                flag_mismatch("token with nothing owed, class", m_tuser, -1);
            else
                check_token(pending_tokens.pop_front());
        end
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int   total;
        int   n_dir;
        int   pause_at;
        int   n;
        row_t r;

        pause_at = 0;

        // Directed rows: byte extremes, carriage returns, delimiters that are
        // data in the wrong phase, the Accept match and an empty header name.
        add_row(ROW_GIVEN,   8'h00,   make_token(CLS_METHOD, 8'h00, 1'b0, HDR_OTHER, 5'd0, 1'b0));
        add_row(ROW_GIVEN,   8'hff,   make_token(CLS_METHOD, 8'hff, 1'b0, HDR_OTHER, 5'd0, 1'b0));
        add_row(ROW_DROPPED, BYTE_CR, '0);
        // LF inside the method is plain data
        add_row(ROW_GIVEN,   BYTE_LF, make_token(CLS_METHOD, 8'h0a, 1'b0, HDR_OTHER, 5'd0, 1'b0));
        add_row(ROW_GIVEN,   BYTE_SP, make_token(CLS_METHOD, 8'h00, 1'b1, HDR_OTHER, 5'd0, 1'b0));
        add_row(ROW_PREDICT, "/",     '0);
        add_row(ROW_PREDICT, 8'h80,   '0);
        add_row(ROW_GIVEN,   BYTE_SP, make_token(CLS_PATH, 8'h00, 1'b1, HDR_OTHER, 5'd0, 1'b0));
        add_row(ROW_PREDICT, "H",     '0);
        // a space in the protocol is kept as data
        add_row(ROW_GIVEN,   BYTE_SP, make_token(CLS_PROTOCOL, 8'h20, 1'b0, HDR_OTHER, 5'd0, 1'b0));
        add_row(ROW_DROPPED, BYTE_CR, '0);
        add_row(ROW_GIVEN,   BYTE_LF, make_token(CLS_PROTOCOL, 8'h00, 1'b1, HDR_OTHER, 5'd0, 1'b0));
        // spaces are skipped inside a header name
        add_row(ROW_DROPPED, BYTE_SP, '0);
        add_row(ROW_PREDICT, "A",     '0);
        add_row(ROW_PREDICT, "c",     '0);
        add_row(ROW_PREDICT, "c",     '0);
        add_row(ROW_PREDICT, "e",     '0);
        add_row(ROW_PREDICT, "p",     '0);
        add_row(ROW_PREDICT, "t",     '0);
        add_row(ROW_GIVEN,   BYTE_COLON,
                make_token(CLS_HNAME, 8'h00, 1'b1, HDR_ACCEPT, 5'd0, 1'b0));
        // leading space of the value is trimmed
        add_row(ROW_DROPPED, BYTE_SP, '0);
        add_row(ROW_PREDICT, 8'h7f,   '0);
        add_row(ROW_GIVEN,   BYTE_LF, make_token(CLS_HVALUE, 8'h00, 1'b1, HDR_ACCEPT, 5'd0, 1'b0));
        // empty header name with an empty value
        add_row(ROW_GIVEN,   BYTE_COLON,
                make_token(CLS_HNAME, 8'h00, 1'b1, HDR_OTHER, 5'd1, 1'b0));
        add_row(ROW_GIVEN,   BYTE_LF, make_token(CLS_HVALUE, 8'h00, 1'b1, HDR_OTHER, 5'd1, 1'b0));

        // Headers: mostly well-formed, with exact names, near misses, spaced
        // names, random names and names past the match window.
        for (int k = 0; k < HDR_COUNT; k++)
        begin
            if (k == 12)
                pause_at = body_bytes.size();
            case ($urandom_range(0, 9))
                0:       push_text("Content-Type");
                1:       push_text("Accept");
                2:       push_text("Content-Typ");
                3:       push_text("Content-Types");
                4:       push_text("Accepts");
                5:       push_text(" Content - Type ");   // spaces drop out, still a match
                6:       push_text("accept");
                7:       ;                                // empty name
                8:       repeat ($urandom_range(1, 8))
                             body_bytes.push_back(rand_data(BYTE_LF, BYTE_COLON));
                default: repeat ($urandom_range(14, 20))
                             body_bytes.push_back(rand_data(BYTE_LF, BYTE_COLON));
            endcase
            body_bytes.push_back(BYTE_COLON);
            repeat ($urandom_range(0, 2))
                body_bytes.push_back(BYTE_SP);
            n = (k == 3) ? LONG_VALUE_LEN : $urandom_range(0, 12);
            repeat (n)
                body_bytes.push_back(rand_data(BYTE_LF, BYTE_LF));
            if ($urandom_range(0, 1))
                body_bytes.push_back(BYTE_CR);
            body_bytes.push_back(BYTE_LF);
        end

        // End the headers with a blank line or with an abandoned name.
        if ($urandom_range(0, 1))
        begin
            body_bytes.push_back(BYTE_CR);
            body_bytes.push_back(BYTE_LF);
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                body_bytes.push_back(rand_data(BYTE_LF, BYTE_COLON));
            body_bytes.push_back(BYTE_LF);
        end

        // Query pairs; the last one ends on LF, either after its value or
        // straight after its key.
        for (int k = 0; k < QUERY_PAIRS; k++)
        begin
            repeat ($urandom_range(0, 6))
                body_bytes.push_back(rand_data(BYTE_EQ, BYTE_LF));
            if (k == QUERY_PAIRS - 1 && $urandom_range(0, 1))
                body_bytes.push_back(BYTE_LF);
            else
            begin
                body_bytes.push_back(BYTE_EQ);
                repeat ($urandom_range(0, 6))
                    body_bytes.push_back(rand_data(BYTE_AMP, BYTE_LF));
                body_bytes.push_back((k == QUERY_PAIRS - 1) ? BYTE_LF : BYTE_AMP);
            end
        end

        // Trailing bytes after the request: the block must stay silent.
        repeat (DONE_TAIL)
            body_bytes.push_back(8'($urandom_range(0, 255)));

        // Hold reset, then release it on a rising edge.
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        n_dir = directed_rows.size();
        total = n_dir + body_bytes.size();
        for (int i = 0; i < total; i++)
        begin
            // idle mix: sender light / receiver heavy, then swapped, then none
            case (i * 3 / total)
                0:
                begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 72;
                end
                1:
                begin
                    tx_idle_pct = 72;
                    rx_idle_pct = 27;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // once, hold the sender until every owed token has come out
            if (i == n_dir + pause_at)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_tokens.size() != 0)
                    @(posedge clk);
            end
            if (i < n_dir)
                r = directed_rows[i];
            else
            begin
                r.kind = ROW_PREDICT;
                r.data = body_bytes[i - n_dir];
                r.tok  = '0;
            end
            feed(r);
        end
        s_tvalid <= 1'b0;

        // Drain: wait for the owed tokens, then give silent bytes time to
        // pass through both pipeline registers.
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d request bytes and %0d tokens: request line, %0d headers",
                 bytes_sent, tokens_checked, HDR_COUNT + 2);
        $display("with name matches and near misses, a %0d-byte value, %0d query pairs",
                 LONG_VALUE_LEN, QUERY_PAIRS);
        if (mismatches == 0)
            $display("http_request_tokenizer verification clean");
        else
            $display("http_request_tokenizer verification failed");
        $finish;
    end

    // Watchdog: if the run has not finished by the timeout below, report a failure and stop.
    initial
    begin
        #2_000_000;
        $display("TIMEOUT after %0d bytes, %0d tokens owed", bytes_sent, pending_tokens.size());
        $display("http_request_tokenizer verification failed");
        $finish;
    end

endmodule
